@@ sv/tsb_pkg.sv @@
// Shared constants, request codes and control/status types of the scrollback buffer.
package tsb_pkg;

  localparam int LINES   = 256;
  localparam int COLS    = 80;
  localparam int VISIBLE = 24;

  localparam int ROW_W     = $clog2(LINES);
  localparam int CIDX_W    = $clog2(COLS);
  localparam int WCOL_W    = $clog2(COLS + 1);
  localparam int LT_W      = $clog2(LINES + 2);
  localparam int CW        = (LT_W > 10 ? LT_W : 10) + 1;
  localparam int ADDR_W    = ROW_W + CIDX_W;
  localparam int MEM_DEPTH = LINES << CIDX_W;

  localparam logic [2:0] REQ_PUT  = 3'd0;
  localparam logic [2:0] REQ_UP   = 3'd1;
  localparam logic [2:0] REQ_DOWN = 3'd2;
  localparam logic [2:0] REQ_SNAP = 3'd3;
  localparam logic [2:0] REQ_READ = 3'd4;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] BLANK_RESET  = 8'h07;
  localparam int         TAB_STEP     = 4;

  typedef struct packed {
    logic load;       // capture the request fields
    logic exec;       // apply a put / scroll / snap request
    logic clr;        // write one blank cell of the current row
    logic clr_init;   // blank color is the reset color
    logic map1;       // first half of the screen-to-ring mapping
    logic map2;       // second half, ring row index
    logic rd;         // read the cell memory
    logic fin_plain;  // emit a non-read result
    logic fin_read;   // emit a read result
  } tsb_cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_newline;
    logic clr_last;
  } tsb_sts_t;

endpackage

@@ sv/tsb_ctrl.sv @@
// Request sequencer of the scrollback buffer.
module tsb_ctrl import tsb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  tsb_sts_t sts,
  output tsb_cmd_t cmd,
  output logic     busy,
  output logic     out_valid
);

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_EXEC  = 8'b0000_0100,
    S_CLEAR = 8'b0000_1000,
    S_MAP1  = 8'b0001_0000,
    S_MAP2  = 8'b0010_0000,
    S_RD    = 8'b0100_0000,
    S_RDOUT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.clr      = 1'b1;
        cmd.clr_init = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_read) begin
          state_nxt = S_MAP1;
        end else begin
          cmd.exec = 1'b1;
          if (sts.is_newline) begin
            state_nxt = S_CLEAR;
          end else begin
            cmd.fin_plain = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          cmd.fin_plain = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_MAP1: begin
        cmd.map1  = 1'b1;
        state_nxt = S_MAP2;
      end
      S_MAP2: begin
        cmd.map2  = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_RDOUT;
      end
      S_RDOUT: begin
        cmd.fin_read = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.fin_plain | cmd.fin_read;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ sv/tsb_datapath.sv @@
// Cell memory, cursor/view registers and screen mapping of the scrollback buffer.
module tsb_datapath import tsb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  tsb_cmd_t    cmd,
  output tsb_sts_t    sts,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_char_color,
  input  logic [9:0]  in_amount,
  input  logic [4:0]  in_screen_row,
  input  logic [6:0]  in_screen_col,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_blank_color,
  output logic [7:0]  out_cell_char,
  output logic [7:0]  out_cell_color,
  output logic        out_cell_shown,
  output logic        out_is_scrolled,
  output logic [7:0]  out_lines_back
);

  logic [15:0] mem [MEM_DEPTH];
  logic [15:0] mem_q;

  logic [2:0]  req_r;
  logic [7:0]  code_r, color_r;
  logic [9:0]  amount_r;
  logic [4:0]  srow_r;
  logic [6:0]  scol_r;

  logic [7:0]        blank_color_r;
  logic [ROW_W-1:0]  write_row_r, write_row_nxt;
  logic [WCOL_W-1:0] write_col_r, write_col_nxt;
  logic [LT_W-1:0]   line_total_r, line_total_nxt;
  logic [ROW_W-1:0]  view_off_r, view_off_nxt;
  logic [CIDX_W-1:0] clr_col_r;

  logic [CW-1:0]     first_r, rowrel_r;
  logic              ok_r;
  logic [ROW_W-1:0]  oldest_r, idx_r;

  logic [7:0] cell_char_r, cell_color_r;
  logic       cell_shown_r;

  logic [CW-1:0] lt_c, count_c, shown_c, top_c, base_c, vo_c, amt_c, row_c, col_c;
  logic [CW-1:0] limit_c, upsum_c, tab_c, logical_c, ringsum_c, wcol_c;
  logic [ROW_W-1:0] wr_inc_c;
  logic printable_c, put_wr_c;
  logic mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0] mem_wdata;

  // Derived history figures.
  always_comb begin
    lt_c      = CW'(line_total_r);
    count_c   = (lt_c < CW'(LINES)) ? lt_c : CW'(LINES);
    shown_c   = (count_c < CW'(VISIBLE)) ? count_c : CW'(VISIBLE);
    top_c     = CW'(VISIBLE) - shown_c;
    base_c    = count_c - shown_c;
    vo_c      = CW'(view_off_r);
    amt_c     = CW'(amount_r);
    row_c     = CW'(srow_r);
    col_c     = CW'(scol_r);
    wcol_c    = CW'(write_col_r);
    limit_c   = count_c - CW'(VISIBLE);
    upsum_c   = vo_c + amt_c;
    tab_c     = (wcol_c + CW'(TAB_STEP)) & ~CW'(TAB_STEP - 1);
    logical_c = first_r + rowrel_r;
    ringsum_c = CW'(oldest_r) + logical_c;
    wr_inc_c  = (write_row_r == ROW_W'(LINES - 1)) ? '0 : write_row_r + ROW_W'(1);
    printable_c = (code_r >= CH_SPACE) && !code_r[7];
    put_wr_c  = (req_r == REQ_PUT) && printable_c && (wcol_c < CW'(COLS));
  end

  assign sts.is_read    = (req_r == REQ_READ);
  assign sts.is_newline = (req_r == REQ_PUT) && (code_r == CH_NEWLINE);
  assign sts.clr_last   = (clr_col_r == CIDX_W'(COLS - 1));

  // Next cursor and view state for put / scroll / snap.
  always_comb begin
    write_row_nxt  = write_row_r;
    write_col_nxt  = write_col_r;
    line_total_nxt = line_total_r;
    view_off_nxt   = view_off_r;
    case (req_r)
      REQ_PUT: begin
        case (code_r)
          CH_NEWLINE: begin
            write_row_nxt = wr_inc_c;
            write_col_nxt = '0;
            if (lt_c < CW'(LINES + 1)) line_total_nxt = line_total_r + LT_W'(1);
          end
          CH_RETURN: ;
          CH_BACKSPACE: begin
            if (write_col_r != '0) write_col_nxt = write_col_r - WCOL_W'(1);
          end
          CH_TAB: begin
            write_col_nxt = (tab_c >= CW'(COLS)) ? WCOL_W'(COLS - 1) : WCOL_W'(tab_c);
          end
          default: begin
            if (put_wr_c) write_col_nxt = write_col_r + WCOL_W'(1);
          end
        endcase
      end
      REQ_UP: begin
        if (count_c >= CW'(VISIBLE))
          view_off_nxt = (upsum_c > limit_c) ? ROW_W'(limit_c) : ROW_W'(upsum_c);
      end
      REQ_DOWN: view_off_nxt = (vo_c > amt_c) ? ROW_W'(vo_c - amt_c) : '0;
      REQ_SNAP: view_off_nxt = '0;
      default: ;
    endcase
  end

  // Memory write port: row clearing has priority over a character store.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {write_row_r, clr_col_r};
    mem_wdata = {(cmd.clr_init ? BLANK_RESET : blank_color_r), CH_SPACE};
    if (cmd.clr) begin
      mem_we = 1'b1;
    end else if (cmd.exec && put_wr_c) begin
      mem_we    = 1'b1;
      mem_waddr = {write_row_r, CIDX_W'(write_col_r)};
      mem_wdata = {color_r, code_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.rd) mem_q <= mem[{idx_r, CIDX_W'(scol_r)}];
  end

  // Request capture, mapping pipeline and result registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= in_req_type;
      code_r   <= in_char_code;
      color_r  <= in_char_color;
      amount_r <= in_amount;
      srow_r   <= in_screen_row;
      scol_r   <= in_screen_col;
    end
    if (cmd.map1) begin
      ok_r     <= (row_c < CW'(VISIBLE)) && (col_c < CW'(COLS)) && (row_c >= top_c);
      first_r  <= (base_c > vo_c) ? base_c - vo_c : '0;
      rowrel_r <= row_c - top_c;
      oldest_r <= (lt_c <= CW'(LINES)) ? '0 : wr_inc_c;
    end
    if (cmd.map2)
      idx_r <= (ringsum_c >= CW'(LINES)) ? ROW_W'(ringsum_c - CW'(LINES)) : ROW_W'(ringsum_c);
    if (cmd.fin_plain) begin
      cell_char_r  <= CH_SPACE;
      cell_color_r <= blank_color_r;
      cell_shown_r <= 1'b0;
    end else if (cmd.fin_read) begin
      cell_char_r  <= ok_r ? mem_q[7:0] : CH_SPACE;
      cell_color_r <= ok_r ? mem_q[15:8] : blank_color_r;
      cell_shown_r <= ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_color_r <= BLANK_RESET;
      write_row_r   <= '0;
      write_col_r   <= '0;
      line_total_r  <= LT_W'(1);
      view_off_r    <= '0;
      clr_col_r     <= '0;
    end else begin
      if (cfg_we) blank_color_r <= cfg_blank_color;
      if (cmd.exec) begin
        write_row_r  <= write_row_nxt;
        write_col_r  <= write_col_nxt;
        line_total_r <= line_total_nxt;
        view_off_r   <= view_off_nxt;
      end
      if (cmd.clr) clr_col_r <= sts.clr_last ? '0 : clr_col_r + CIDX_W'(1);
    end
  end

  assign out_cell_char   = cell_char_r;
  assign out_cell_color  = cell_color_r;
  assign out_cell_shown  = cell_shown_r;
  assign out_is_scrolled = (view_off_r != '0);
  assign out_lines_back  = 8'(view_off_r);

endmodule

@@ sv/text_scrollback_buffer_core.sv @@
// Top level of the text console scrollback buffer.
//
// Usage:
//   Request channel: drive in_* and raise start; the request is taken at a
//   rising edge where start is high and busy is low. in_req_type selects put
//   character, scroll up, scroll down, snap to live or read screen cell.
//   Result channel: every request yields one result, held on out_* for one
//   cycle while out_valid is high. The receiver cannot stall it.
//   Config channel: cfg_blank_color is written when cfg_valid and cfg_ready
//   are both high; cfg_ready is always high. Write only while idle.
// Steps from accept to result strobe:
//   put / scroll / snap: one execute step, then the result register.
//   newline: an execute step, then the cell memory's single write port blanks
//   the new line one cell per cycle, then the result register.
//   screen-cell read: a decode step, two mapping stages, one registered
//   memory read, then the output capture together with the result register.
//   A new request can be taken in the cycle the previous result is shown.
// Reset: synchronous, active low. Cursor and view clear, the line total
//   returns to 1, blank color returns to 7, and busy stays high while the
//   first line is blanked; later lines are blanked when begun by a newline.
module text_scrollback_buffer_core import tsb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_req_type,
  input  logic [7:0] in_char_code,
  input  logic [7:0] in_char_color,
  input  logic [9:0] in_amount,
  input  logic [4:0] in_screen_row,
  input  logic [6:0] in_screen_col,
  output logic       out_valid,
  output logic [7:0] out_cell_char,
  output logic [7:0] out_cell_color,
  output logic       out_cell_shown,
  output logic       out_is_scrolled,
  output logic [7:0] out_lines_back,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_blank_color
);

  tsb_cmd_t cmd;
  tsb_sts_t sts;

  // Register writes never wait.
  assign cfg_ready = 1'b1;

  tsb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  tsb_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_req_type),
    .in_char_code    (in_char_code),
    .in_char_color   (in_char_color),
    .in_amount       (in_amount),
    .in_screen_row   (in_screen_row),
    .in_screen_col   (in_screen_col),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_blank_color (cfg_blank_color),
    .out_cell_char   (out_cell_char),
    .out_cell_color  (out_cell_color),
    .out_cell_shown  (out_cell_shown),
    .out_is_scrolled (out_is_scrolled),
    .out_lines_back  (out_lines_back)
  );

endmodule
